>>> design/nrth_pkg.sv
// shared types and constants of the nearest ray triangle hit core
package nrth_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int INDEX_WIDTH_DEF = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	localparam logic [31:0] THRESH_RESET = 32'd1638;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z          = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_MODE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd7;

	// sequencer steps of the back end, one product each
	localparam logic [5:0] ST_NRM  = 6'd0;
	localparam logic [5:0] ST_NUM  = 6'd6;
	localparam logic [5:0] ST_DEN  = 6'd9;
	localparam logic [5:0] ST_PT   = 6'd12;
	localparam logic [5:0] ST_BABA = 6'd15;
	localparam logic [5:0] ST_CABA = 6'd18;
	localparam logic [5:0] ST_CACA = 6'd21;
	localparam logic [5:0] ST_D02  = 6'd24;
	localparam logic [5:0] ST_D12  = 6'd27;
	localparam logic [5:0] ST_DD0  = 6'd30;
	localparam logic [5:0] ST_DD1  = 6'd31;
	localparam logic [5:0] ST_U0   = 6'd32;
	localparam logic [5:0] ST_U1   = 6'd33;
	localparam logic [5:0] ST_V0   = 6'd34;
	localparam logic [5:0] ST_V1   = 6'd35;
	localparam logic [5:0] ST_SQ   = 6'd36;
	localparam logic [5:0] ST_END  = 6'd38;

	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][31:0] d;
		logic             seg;
		logic [31:0]      thr;
	} cfg_t;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0][32:0] e1;
		logic [2:0][32:0] e2;
		logic [2:0][32:0] w;
		logic             last;
	} tri_t;

endpackage

>>> design/nrth_front.sv
// front end: takes triangles, forms edge and offset vectors, pushes to the queue
module nrth_front #(
	parameter int INDEX_WIDTH = nrth_pkg::INDEX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nrth_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            vertex_a_x,
	input  logic [31:0]            vertex_a_y,
	input  logic [31:0]            vertex_a_z,
	input  logic [31:0]            vertex_b_x,
	input  logic [31:0]            vertex_b_y,
	input  logic [31:0]            vertex_b_z,
	input  logic [31:0]            vertex_c_x,
	input  logic [31:0]            vertex_c_y,
	input  logic [31:0]            vertex_c_z,
	input  logic [INDEX_WIDTH-1:0] tri_index,
	input  logic                   last,
	input  logic                   q_full,
	output logic                   q_push,
	output nrth_pkg::tri_t         q_tri,
	output logic [INDEX_WIDTH-1:0] q_idx
);

	logic                   valid_s1;
	nrth_pkg::tri_t         tri_s1;
	logic [INDEX_WIDTH-1:0] idx_s1;
	nrth_pkg::tri_t         tri_d;
	logic [2:0][31:0]       va, vb, vc;
	logic                   accept;

	assign va = {vertex_a_z, vertex_a_y, vertex_a_x};
	assign vb = {vertex_b_z, vertex_b_y, vertex_b_x};
	assign vc = {vertex_c_z, vertex_c_y, vertex_c_x};

	always_comb begin
		tri_d.a = va;
		tri_d.last = last;
		for (int k = 0; k < 3; k++) begin
			tri_d.e1[k] = {vb[k][31], vb[k]} - {va[k][31], va[k]};
			tri_d.e2[k] = {vc[k][31], vc[k]} - {va[k][31], va[k]};
			tri_d.w[k]  = {va[k][31], va[k]} - {cfg.o[k][31], cfg.o[k]};
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_tri    = tri_s1;
	assign q_idx    = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tri_s1 <= tri_d;
			idx_s1 <= tri_index;
		end
	end

endmodule

>>> design/nrth_queue.sv
// two-entry queue between front and back end
module nrth_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             not_empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

>>> design/nrth_mul.sv
// shared 64x64 signed multiplier, four 32x32 partial products
module nrth_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	output logic                 done,
	output logic signed [127:0]  p
);

	logic [63:0]  ma_q, mb_q;
	logic         neg_q, busy_q, done_q;
	logic [1:0]   cnt_q;
	logic [127:0] acc_q;
	logic [31:0]  ha, hb;
	logic [63:0]  pp;
	logic [127:0] pps;

	always_comb begin
		ha = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		hb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = ha * hb;
		unique case (cnt_q)
			2'd0: pps = {64'b0, pp};
			2'd1, 2'd2: pps = {32'b0, pp, 32'b0};
			default: pps = {pp, 64'b0};
		endcase
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ma_q  <= a[63] ? 64'(-a) : a;
			mb_q  <= b[63] ? 64'(-b) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pps;
		end
	end

endmodule

>>> design/nrth_div.sv
// restoring divider for the ray parameter, one quotient bit per cycle
module nrth_div #(
	parameter int FRAC_BITS = nrth_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] m,
	input  logic [63:0] dv,
	output logic        done,
	output logic [63:0] q
);

	localparam int L  = 64 + FRAC_BITS;
	localparam int CW = $clog2(L + 1);

	logic [L-1:0]  num_q, quo_q;
	logic [63:0]   rem_q, dv_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [64:0]   remsh;
	logic          qbit;
	logic [64:0]   rem_d;

	always_comb begin
		remsh = {rem_q, num_q[L-1]};
		qbit  = remsh >= {1'b0, dv_q};
		rem_d = qbit ? remsh - {1'b0, dv_q} : remsh;
	end

	assign done = done_q;
	assign q    = (|quo_q[L-1:63]) ? {1'b0, {63{1'b1}}} : {1'b0, quo_q[62:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(L);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= {m, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			dv_q  <= dv;
		end else if (busy_q) begin
			num_q <= {num_q[L-2:0], 1'b0};
			quo_q <= {quo_q[L-2:0], qbit};
			rem_q <= rem_d[63:0];
		end
	end

endmodule

>>> design/nrth_back.sv
// back end: sequences the intersection math, keeps the nearest hit, emits the run result
module nrth_back #(
	parameter int FRAC_BITS   = nrth_pkg::FRAC_BITS_DEF,
	parameter int INDEX_WIDTH = nrth_pkg::INDEX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nrth_pkg::cfg_t         cfg,
	input  logic                   q_valid,
	input  nrth_pkg::tri_t         q_tri,
	input  logic [INDEX_WIDTH-1:0] q_idx,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic [31:0]            hit_point_x,
	output logic [31:0]            hit_point_y,
	output logic [31:0]            hit_point_z,
	output logic [63:0]            hit_sqr_distance,
	output logic [INDEX_WIDTH-1:0] hit_index
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_CHK  = 6'b000100,
		S_DIV  = 6'b001000,
		S_FIN  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	localparam logic [5:0] ST_NUM_L = nrth_pkg::ST_NUM;

	function automatic logic signed [63:0] sx32(input logic [31:0] v);
		sx32 = {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [63:0] sx33(input logic [32:0] v);
		sx33 = {{31{v[32]}}, v};
	endfunction

	function automatic logic signed [63:0] sat_w(input logic signed [127:0] v);
		if (v[127:63] == '0 || v[127:63] == '1) sat_w = v[63:0];
		else if (v[127]) sat_w = {1'b1, 63'b0};
		else sat_w = {1'b0, {63{1'b1}}};
	endfunction

	function automatic logic signed [63:0] sat_s(input logic signed [64:0] v);
		if (v[64] == v[63]) sat_s = v[63:0];
		else if (v[64]) sat_s = {1'b1, 63'b0};
		else sat_s = {1'b0, {63{1'b1}}};
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : v;
	endfunction

	state_t                 state_q;
	nrth_pkg::tri_t         tri_q;
	logic [INDEX_WIDTH-1:0] idx_q;
	logic [5:0]             step_q;
	logic                   mgo_q, dgo_q, hit_q;
	logic signed [63:0]     tmp_q, acc_q, num_q, den_q;
	logic signed [63:0]     n_q [3];
	logic [63:0]            t_q;
	logic [31:0]            pt_q [3];
	logic signed [63:0]     baba_q, caba_q, caca_q, d02_q, d12_q;
	logic signed [127:0]    wide_q, dd_q, uu_q;
	logic [63:0]            dist_q;
	logic [63:0]            bestd_q;
	logic [31:0]            bestp_q [3];
	logic [INDEX_WIDTH-1:0] bestt_q;
	logic                   found_q, stopped_q;
	logic                   out_valid_q, hit_o_q;
	logic [31:0]            px_q, py_q, pz_q;
	logic [63:0]            od_q;
	logic [INDEX_WIDTH-1:0] oi_q;

	logic signed [63:0]  ma, mb;
	logic [1:0]          kk;
	logic [5:0]          rel;
	logic signed [63:0]  vp [3];
	logic signed [63:0]  pto [3];
	logic                m_done, d_done;
	logic signed [127:0] mp;
	logic [63:0]         dq;
	logic signed [63:0]  mf, accsum, nsub, sclamp, ov;
	logic [31:0]         ptv;
	logic [63:0]         usq, dnext;
	logic [64:0]         ds;
	logic signed [127:0] uvd;
	logic                grp_end;
	logic [63:0]         thr_sh;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vp[k]  = sx32(pt_q[k]) - sx32(tri_q.a[k]);
			pto[k] = sx32(pt_q[k]) - sx32(cfg.o[k]);
		end
		ma  = '0;
		mb  = '0;
		rel = '0;
		priority if (step_q < ST_NUM_L) begin
			unique case (step_q)
				nrth_pkg::ST_NRM: begin
					ma = sx33(tri_q.e1[1]); mb = sx33(tri_q.e2[2]);
				end
				nrth_pkg::ST_NRM + 6'd1: begin
					ma = sx33(tri_q.e1[2]); mb = sx33(tri_q.e2[1]);
				end
				nrth_pkg::ST_NRM + 6'd2: begin
					ma = sx33(tri_q.e1[2]); mb = sx33(tri_q.e2[0]);
				end
				nrth_pkg::ST_NRM + 6'd3: begin
					ma = sx33(tri_q.e1[0]); mb = sx33(tri_q.e2[2]);
				end
				nrth_pkg::ST_NRM + 6'd4: begin
					ma = sx33(tri_q.e1[0]); mb = sx33(tri_q.e2[1]);
				end
				default: begin
					ma = sx33(tri_q.e1[1]); mb = sx33(tri_q.e2[0]);
				end
			endcase
		end else if (step_q < nrth_pkg::ST_DEN) begin
			rel = step_q - nrth_pkg::ST_NUM;
		end else if (step_q < nrth_pkg::ST_PT) begin
			rel = step_q - nrth_pkg::ST_DEN;
		end else if (step_q < nrth_pkg::ST_BABA) begin
			rel = step_q - nrth_pkg::ST_PT;
		end else if (step_q < nrth_pkg::ST_CABA) begin
			rel = step_q - nrth_pkg::ST_BABA;
		end else if (step_q < nrth_pkg::ST_CACA) begin
			rel = step_q - nrth_pkg::ST_CABA;
		end else if (step_q < nrth_pkg::ST_D02) begin
			rel = step_q - nrth_pkg::ST_CACA;
		end else if (step_q < nrth_pkg::ST_D12) begin
			rel = step_q - nrth_pkg::ST_D02;
		end else if (step_q < nrth_pkg::ST_DD0) begin
			rel = step_q - nrth_pkg::ST_D12;
		end else if (step_q >= nrth_pkg::ST_SQ) begin
			rel = step_q - nrth_pkg::ST_SQ;
		end else begin
			rel = '0;
		end
		kk = rel[1:0];
		if (step_q >= ST_NUM_L) begin
			priority if (step_q < nrth_pkg::ST_DEN) begin
				ma = sx33(tri_q.w[kk]); mb = n_q[kk];
			end else if (step_q < nrth_pkg::ST_PT) begin
				ma = sx32(cfg.d[kk]); mb = n_q[kk];
			end else if (step_q < nrth_pkg::ST_BABA) begin
				ma = sx32(cfg.d[kk]); mb = t_q;
			end else if (step_q < nrth_pkg::ST_CABA) begin
				ma = sx33(tri_q.e1[kk]); mb = sx33(tri_q.e1[kk]);
			end else if (step_q < nrth_pkg::ST_CACA) begin
				ma = sx33(tri_q.e2[kk]); mb = sx33(tri_q.e1[kk]);
			end else if (step_q < nrth_pkg::ST_D02) begin
				ma = sx33(tri_q.e2[kk]); mb = sx33(tri_q.e2[kk]);
			end else if (step_q < nrth_pkg::ST_D12) begin
				ma = sx33(tri_q.e2[kk]); mb = vp[kk];
			end else if (step_q < nrth_pkg::ST_DD0) begin
				ma = sx33(tri_q.e1[kk]); mb = vp[kk];
			end else if (step_q == nrth_pkg::ST_DD0) begin
				ma = caca_q; mb = baba_q;
			end else if (step_q == nrth_pkg::ST_DD1) begin
				ma = caba_q; mb = caba_q;
			end else if (step_q == nrth_pkg::ST_U0) begin
				ma = baba_q; mb = d02_q;
			end else if (step_q == nrth_pkg::ST_U1) begin
				ma = caba_q; mb = d12_q;
			end else if (step_q == nrth_pkg::ST_V0) begin
				ma = caca_q; mb = d12_q;
			end else if (step_q == nrth_pkg::ST_V1) begin
				ma = caba_q; mb = d02_q;
			end else begin
				ma = pto[kk]; mb = pto[kk];
			end
		end
	end

	nrth_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mgo_q),
		.a      (ma),
		.b      (mb),
		.done   (m_done),
		.p      (mp)
	);

	nrth_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dgo_q),
		.m      (mag64(num_q)),
		.dv     (mag64(den_q)),
		.done   (d_done),
		.q      (dq)
	);

	always_comb begin
		mf     = sat_w(mp >>> FRAC_BITS);
		accsum = sat_s({acc_q[63], acc_q} + {mf[63], mf});
		nsub   = sat_s({tmp_q[63], tmp_q} - {mf[63], mf});
		if (mf > 64'sh100_0000_0000) sclamp = 64'sh100_0000_0000;
		else if (mf < -64'sh100_0000_0000) sclamp = -64'sh100_0000_0000;
		else sclamp = mf;
		ov = sx32(cfg.o[kk]) + sclamp;
		if (ov > 64'sh7fff_ffff) ptv = 32'h7fff_ffff;
		else if (ov < -64'sh8000_0000) ptv = 32'h8000_0000;
		else ptv = ov[31:0];
		usq     = (|mp[127:64]) ? '1 : mp[63:0];
		ds      = {1'b0, dist_q} + {1'b0, usq};
		dnext   = ds[64] ? '1 : ds[63:0];
		uvd     = uu_q + wide_q - dd_q;
		grp_end = kk == 2'd2;
		thr_sh  = {32'b0, cfg.thr} << FRAC_BITS;
	end

	assign q_pop            = (state_q == S_IDLE) && q_valid;
	assign out_valid        = out_valid_q;
	assign hit              = hit_o_q;
	assign hit_point_x      = px_q;
	assign hit_point_y      = py_q;
	assign hit_point_z      = pz_q;
	assign hit_sqr_distance = od_q;
	assign hit_index        = oi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			mgo_q       <= 1'b0;
			dgo_q       <= 1'b0;
			hit_q       <= 1'b0;
			bestd_q     <= '1;
			bestp_q     <= '{default: '0};
			bestt_q     <= '0;
			found_q     <= 1'b0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mgo_q <= 1'b0;
			dgo_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (stopped_q) begin
							hit_q   <= 1'b0;
							state_q <= S_FIN;
						end else begin
							step_q  <= nrth_pkg::ST_NRM;
							mgo_q   <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (m_done) begin
						if (step_q == nrth_pkg::ST_NUM - 6'd1 ||
						    step_q == nrth_pkg::ST_PT - 6'd1 ||
						    step_q == nrth_pkg::ST_DD1 || step_q == nrth_pkg::ST_V1 ||
						    step_q == nrth_pkg::ST_END) begin
							state_q <= S_CHK;
						end else begin
							step_q <= step_q + 6'd1;
							mgo_q  <= 1'b1;
						end
					end
				end
				S_CHK: begin
					unique case (step_q)
						nrth_pkg::ST_NUM - 6'd1: begin
							if (n_q[0] == 0 && n_q[1] == 0 && n_q[2] == 0) begin
								hit_q   <= 1'b0;
								state_q <= S_FIN;
							end else begin
								step_q  <= nrth_pkg::ST_NUM;
								mgo_q   <= 1'b1;
								state_q <= S_MUL;
							end
						end
						nrth_pkg::ST_PT - 6'd1: begin
							if (den_q == 0 || (num_q != 0 && num_q[63] != den_q[63]) ||
							    (cfg.seg && mag64(num_q) > mag64(den_q))) begin
								hit_q   <= 1'b0;
								state_q <= S_FIN;
							end else begin
								dgo_q   <= 1'b1;
								state_q <= S_DIV;
							end
						end
						nrth_pkg::ST_DD1: begin
							if (dd_q[127] || dd_q == 0) begin
								hit_q   <= 1'b0;
								state_q <= S_FIN;
							end else begin
								step_q  <= nrth_pkg::ST_U0;
								mgo_q   <= 1'b1;
								state_q <= S_MUL;
							end
						end
						nrth_pkg::ST_V1: begin
							if (uu_q[127] || wide_q[127] || !uvd[127]) begin
								hit_q   <= 1'b0;
								state_q <= S_FIN;
							end else begin
								step_q  <= nrth_pkg::ST_SQ;
								mgo_q   <= 1'b1;
								state_q <= S_MUL;
							end
						end
						default: begin
							hit_q   <= step_q == nrth_pkg::ST_END;
							state_q <= S_FIN;
						end
					endcase
				end
				S_DIV: begin
					if (d_done) begin
						step_q  <= nrth_pkg::ST_PT;
						mgo_q   <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					if (hit_q && (!found_q || dist_q < bestd_q)) begin
						bestd_q <= dist_q;
						bestp_q <= pt_q;
						bestt_q <= idx_q;
						found_q <= 1'b1;
						if (dist_q < thr_sh) stopped_q <= 1'b1;
					end
					state_q <= tri_q.last ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						bestd_q     <= '1;
						bestp_q     <= '{default: '0};
						bestt_q     <= '0;
						found_q     <= 1'b0;
						stopped_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tri_q  <= q_tri;
			idx_q  <= q_idx;
			acc_q  <= '0;
			dist_q <= '0;
		end
		if (state_q == S_DIV && d_done) t_q <= dq;
		if (state_q == S_EMIT && (!out_valid_q || !out_stall)) begin
			hit_o_q <= found_q;
			px_q    <= bestp_q[0];
			py_q    <= bestp_q[1];
			pz_q    <= bestp_q[2];
			od_q    <= found_q ? bestd_q : '0;
			oi_q    <= bestt_q;
		end
		if (state_q == S_MUL && m_done) begin
			priority if (step_q < ST_NUM_L) begin
				if (!step_q[0]) tmp_q <= mf;
				else n_q[step_q[2:1]] <= nsub;
			end else if (step_q >= nrth_pkg::ST_PT && step_q < nrth_pkg::ST_BABA) begin
				pt_q[kk] <= ptv;
			end else if (step_q < nrth_pkg::ST_DD0) begin
				acc_q <= grp_end ? '0 : accsum;
				if (grp_end) begin
					priority if (step_q < nrth_pkg::ST_DEN) num_q <= accsum;
					else if (step_q < nrth_pkg::ST_PT) den_q <= accsum;
					else if (step_q < nrth_pkg::ST_CABA) baba_q <= accsum;
					else if (step_q < nrth_pkg::ST_CACA) caba_q <= accsum;
					else if (step_q < nrth_pkg::ST_D02) caca_q <= accsum;
					else if (step_q < nrth_pkg::ST_D12) d02_q <= accsum;
					else d12_q <= accsum;
				end
			end else if (step_q == nrth_pkg::ST_DD0 || step_q == nrth_pkg::ST_U0 ||
			             step_q == nrth_pkg::ST_V0) begin
				wide_q <= mp;
			end else if (step_q == nrth_pkg::ST_DD1) begin
				dd_q <= wide_q - mp;
			end else if (step_q == nrth_pkg::ST_U1) begin
				uu_q <= wide_q - mp;
			end else if (step_q == nrth_pkg::ST_V1) begin
				wide_q <= wide_q - mp;
			end else begin
				dist_q <= dnext;
			end
		end
	end

endmodule

>>> design/nearest_ray_triangle_hit_core.sv
// top level of the nearest ray triangle hit core
// Set the ray through the write port (origin, direction, segment mode, near
// threshold) while the core is idle, then send a run of triangles on the input
// channel; the triangle flagged last closes the run. Each run gives one result
// transaction on the output channel: hit flag, nearest hit point, squared
// distance and triangle index, all zero when nothing was hit.
// Both channels move a transaction on a clock edge with valid high and stall low.
// The front end registers each triangle, forms its edge and offset vectors and
// hands it through a two-entry queue to the back end.
// The back end tests one triangle at a time: up to 39 products on one shared
// multiplier, plus a divider for the ray parameter; a miss found early ends the
// test sooner, and a triangle after the early stop skips the products and the divider.
// The result register holds the result while the receiver stalls; the back end
// waits only when a new run result meets a result not yet taken.
// Reset clears the queue, the run state and sets registers to their defaults.
module nearest_ray_triangle_hit_core #(
	parameter int FRAC_BITS   = nrth_pkg::FRAC_BITS_DEF,
	parameter int INDEX_WIDTH = nrth_pkg::INDEX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nrth_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nrth_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     vertex_a_x,
	input  logic [31:0]                     vertex_a_y,
	input  logic [31:0]                     vertex_a_z,
	input  logic [31:0]                     vertex_b_x,
	input  logic [31:0]                     vertex_b_y,
	input  logic [31:0]                     vertex_b_z,
	input  logic [31:0]                     vertex_c_x,
	input  logic [31:0]                     vertex_c_y,
	input  logic [31:0]                     vertex_c_z,
	input  logic [INDEX_WIDTH-1:0]          tri_index,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [31:0]                     hit_point_x,
	output logic [31:0]                     hit_point_y,
	output logic [31:0]                     hit_point_z,
	output logic [63:0]                     hit_sqr_distance,
	output logic [INDEX_WIDTH-1:0]          hit_index
);

	localparam int QW = $bits(nrth_pkg::tri_t) + INDEX_WIDTH;

	nrth_pkg::cfg_t         cfg_q;
	logic                   q_full, q_push, q_pop, q_valid;
	nrth_pkg::tri_t         f_tri, b_tri;
	logic [INDEX_WIDTH-1:0] f_idx, b_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.o   <= '0;
			cfg_q.d   <= '0;
			cfg_q.seg <= 1'b0;
			cfg_q.thr <= nrth_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nrth_pkg::REG_ORIGIN_X:       cfg_q.o[0] <= cfg_data;
				nrth_pkg::REG_ORIGIN_Y:       cfg_q.o[1] <= cfg_data;
				nrth_pkg::REG_ORIGIN_Z:       cfg_q.o[2] <= cfg_data;
				nrth_pkg::REG_DIR_X:          cfg_q.d[0] <= cfg_data;
				nrth_pkg::REG_DIR_Y:          cfg_q.d[1] <= cfg_data;
				nrth_pkg::REG_DIR_Z:          cfg_q.d[2] <= cfg_data;
				nrth_pkg::REG_SEGMENT_MODE:   cfg_q.seg  <= cfg_data[0];
				default:                      cfg_q.thr  <= cfg_data;
			endcase
		end
	end

	nrth_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.vertex_a_x (vertex_a_x),
		.vertex_a_y (vertex_a_y),
		.vertex_a_z (vertex_a_z),
		.vertex_b_x (vertex_b_x),
		.vertex_b_y (vertex_b_y),
		.vertex_b_z (vertex_b_z),
		.vertex_c_x (vertex_c_x),
		.vertex_c_y (vertex_c_y),
		.vertex_c_z (vertex_c_z),
		.tri_index  (tri_index),
		.last       (last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_tri      (f_tri),
		.q_idx      (f_idx)
	);

	nrth_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_idx, f_tri}),
		.pop       (q_pop),
		.pop_data  ({b_idx, b_tri}),
		.full      (q_full),
		.not_empty (q_valid)
	);

	nrth_back #(.FRAC_BITS(FRAC_BITS), .INDEX_WIDTH(INDEX_WIDTH)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_tri            (b_tri),
		.q_idx            (b_idx),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.hit_point_x      (hit_point_x),
		.hit_point_y      (hit_point_y),
		.hit_point_z      (hit_point_z),
		.hit_sqr_distance (hit_sqr_distance),
		.hit_index        (hit_index)
	);

endmodule

>>> test/nrth_checker.sv
// checker of the nearest ray triangle hit core: tracks the ray setup, predicts and compares results
`timescale 1ns / 100ps
module nrth_checker #(
	parameter int FRAC_BITS   = nrth_pkg::FRAC_BITS_DEF,
	parameter int INDEX_WIDTH = nrth_pkg::INDEX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nrth_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nrth_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [31:0]                     vertex_a_x,
	input  logic [31:0]                     vertex_a_y,
	input  logic [31:0]                     vertex_a_z,
	input  logic [31:0]                     vertex_b_x,
	input  logic [31:0]                     vertex_b_y,
	input  logic [31:0]                     vertex_b_z,
	input  logic [31:0]                     vertex_c_x,
	input  logic [31:0]                     vertex_c_y,
	input  logic [31:0]                     vertex_c_z,
	input  logic [INDEX_WIDTH-1:0]          tri_index,
	input  logic                            last,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            hit,
	input  logic [31:0]                     hit_point_x,
	input  logic [31:0]                     hit_point_y,
	input  logic [31:0]                     hit_point_z,
	input  logic [63:0]                     hit_sqr_distance,
	input  logic [INDEX_WIDTH-1:0]          hit_index,
	output int                              fail_count,
	output int                              pending_results,
	output int                              result_count,
	output int                              hit_count
);
	import nrth_pkg::*;

	localparam logic signed [127:0] MAX64 = 128'sh0000000000000000_7FFFFFFFFFFFFFFF;
	localparam logic signed [127:0] MIN64 = -MAX64 - 1;

	typedef struct {
		logic                   hit;
		logic [31:0]            px, py, pz;
		logic [63:0]            sq_dist;
		logic [INDEX_WIDTH-1:0] idx;
	} run_result_t;

	run_result_t run_results_q[$];

	longint ray_o[3], ray_d[3];
	logic seg_mode;
	logic [31:0] near_thr;
	logic [63:0] best_dist;
	longint best_pt[3];
	logic [INDEX_WIDTH-1:0] best_idx;
	logic found, stopped;

	function automatic longint sat64(logic signed [127:0] w);
		if (w > MAX64) return longint'(MAX64[63:0]);
		if (w < MIN64) return longint'(MIN64[63:0]);
		return longint'(w[63:0]);
	endfunction

	function automatic logic signed [127:0] wmul(longint x, longint y);
		logic signed [127:0] wx, wy;
		wx = x;
		wy = y;
		return wx * wy;
	endfunction

	function automatic longint mulf(longint x, longint y);
		return sat64(wmul(x, y) >>> FRAC_BITS);
	endfunction

	function automatic longint sadd(longint x, longint y);
		logic signed [127:0] wx, wy;
		wx = x;
		wy = y;
		return sat64(wx + wy);
	endfunction

	function automatic longint dot3(longint x[3], longint y[3]);
		return sadd(sadd(mulf(x[0], y[0]), mulf(x[1], y[1])), mulf(x[2], y[2]));
	endfunction

	function automatic logic [63:0] magn(longint x);
		logic [63:0] u;
		u = x;
		return x < 0 ? -u : u;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic bit ray_hits(input longint a[3], input longint b[3], input longint c[3],
			output longint pt[3], output logic [63:0] sq_dist);
		longint e1[3], e2[3], w[3], n[3], vp[3];
		longint num, den, baba, caba, caca, d02, d12, s, diff;
		logic [127:0] qq;
		logic [63:0] t, v;
		logic [64:0] acc;
		logic signed [127:0] uu, vv, dd, sq, chk;
		for (int k = 0; k < 3; k++) begin
			e1[k] = b[k] - a[k];
			e2[k] = c[k] - a[k];
			w[k] = a[k] - ray_o[k];
		end
		n[0] = sadd(mulf(e1[1], e2[2]), -mulf(e1[2], e2[1]));
		n[1] = sadd(mulf(e1[2], e2[0]), -mulf(e1[0], e2[2]));
		n[2] = sadd(mulf(e1[0], e2[1]), -mulf(e1[1], e2[0]));
		sq_dist = 0;
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) return 0;
		num = dot3(w, n);
		den = dot3(ray_d, n);
		if (den == 0) return 0;
		if (num != 0 && ((num < 0) != (den < 0))) return 0;
		if (seg_mode && magn(num) > magn(den)) return 0;
		qq = ({64'd0, magn(num)} << FRAC_BITS) / {64'd0, magn(den)};
		t = (qq >= 128'h8000000000000000) ? 64'h7FFFFFFFFFFFFFFF : qq[63:0];
		for (int k = 0; k < 3; k++) begin
			s = clampl(mulf(ray_d[k], longint'(t)), -(64'sd1 <<< 40), 64'sd1 <<< 40);
			pt[k] = clampl(ray_o[k] + s, -64'sd2147483648, 64'sd2147483647);
			vp[k] = pt[k] - a[k];
		end
		baba = dot3(e1, e1);
		caba = dot3(e2, e1);
		caca = dot3(e2, e2);
		d02 = dot3(e2, vp);
		d12 = dot3(e1, vp);
		dd = wmul(caca, baba) - wmul(caba, caba);
		if (dd[127] || dd == 0) return 0;
		uu = wmul(baba, d02) - wmul(caba, d12);
		vv = wmul(caca, d12) - wmul(caba, d02);
		if (uu[127] || vv[127]) return 0;
		chk = uu + vv - dd;
		if (!chk[127]) return 0;
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			diff = pt[k] - ray_o[k];
			sq = wmul(diff, diff);
			v = (sq[127:64] != 0) ? 64'hFFFFFFFFFFFFFFFF : sq[63:0];
			acc = acc + v;
			if (acc[64]) acc = {1'b0, 64'hFFFFFFFFFFFFFFFF};
		end
		sq_dist = acc[63:0];
		return 1;
	endfunction

	task automatic clear_run();
		best_dist = '1;
		best_pt = '{0, 0, 0};
		best_idx = '0;
		found = 0;
		stopped = 0;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		fail_count++;
	endtask

	task automatic take_triangle();
		longint a[3], b[3], c[3], pt[3];
		logic [63:0] sq_dist;
		run_result_t r;
		a = '{longint'($signed(vertex_a_x)), longint'($signed(vertex_a_y)),
			longint'($signed(vertex_a_z))};
		b = '{longint'($signed(vertex_b_x)), longint'($signed(vertex_b_y)),
			longint'($signed(vertex_b_z))};
		c = '{longint'($signed(vertex_c_x)), longint'($signed(vertex_c_y)),
			longint'($signed(vertex_c_z))};
		if (!stopped && ray_hits(a, b, c, pt, sq_dist)) begin
			if (!found || sq_dist < best_dist) begin
				best_dist = sq_dist;
				best_pt = pt;
				best_idx = tri_index;
				found = 1;
				if (sq_dist < ({32'd0, near_thr} << FRAC_BITS)) stopped = 1;
			end
		end
		if (last) begin
			r.hit = found;
			r.px = best_pt[0][31:0];
			r.py = best_pt[1][31:0];
			r.pz = best_pt[2][31:0];
			r.sq_dist = found ? best_dist : 64'd0;
			r.idx = best_idx;
			run_results_q.push_back(r);
			clear_run();
		end
	endtask

	task automatic check_result();
		run_result_t r;
		result_count++;
		if (hit) hit_count++;
		if (run_results_q.size() == 0) begin
			$display("result transaction with no run closed");
			fail_count++;
			return;
		end
		r = run_results_q.pop_front();
		if (hit !== r.hit) report("hit", hit, r.hit);
		if (hit_point_x !== r.px) report("hit_point_x", hit_point_x, r.px);
		if (hit_point_y !== r.py) report("hit_point_y", hit_point_y, r.py);
		if (hit_point_z !== r.pz) report("hit_point_z", hit_point_z, r.pz);
		if (hit_sqr_distance !== r.sq_dist)
			report("hit_sqr_distance", hit_sqr_distance, r.sq_dist);
		if (hit_index !== r.idx) report("hit_index", hit_index, r.idx);
	endtask

	assign pending_results = run_results_q.size();

	initial begin
		fail_count = 0;
		result_count = 0;
		hit_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_o = '{0, 0, 0};
			ray_d = '{0, 0, 0};
			seg_mode = 0;
			near_thr = THRESH_RESET;
			clear_run();
		end else begin
			if (out_valid && !out_stall) check_result();
			if (in_valid && !in_stall) take_triangle();
			if (cfg_we) begin
				case (cfg_index)
					REG_ORIGIN_X: ray_o[0] = longint'($signed(cfg_data));
					REG_ORIGIN_Y: ray_o[1] = longint'($signed(cfg_data));
					REG_ORIGIN_Z: ray_o[2] = longint'($signed(cfg_data));
					REG_DIR_X: ray_d[0] = longint'($signed(cfg_data));
					REG_DIR_Y: ray_d[1] = longint'($signed(cfg_data));
					REG_DIR_Z: ray_d[2] = longint'($signed(cfg_data));
					REG_SEGMENT_MODE: seg_mode = cfg_data[0];
					REG_NEAR_THRESHOLD: near_thr = cfg_data;
					default: ;
				endcase
			end
		end
	end

	final begin
		if (run_results_q.size() != 0) ;
	end
endmodule

>>> test/tb_nearest_ray_triangle_hit_core.sv
// testbench top of the nearest ray triangle hit core: ray setup, triangle runs and verdict
`timescale 1ns / 100ps
module tb_nearest_ray_triangle_hit_core;
	import nrth_pkg::*;

	localparam int ITEMS_PER_PHASE = 125;
	localparam int LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [31:0] vertex_a_x, vertex_a_y, vertex_a_z;
	logic [31:0] vertex_b_x, vertex_b_y, vertex_b_z;
	logic [31:0] vertex_c_x, vertex_c_y, vertex_c_z;
	logic [15:0] tri_index;
	logic last;
	logic hit;
	logic [31:0] hit_point_x, hit_point_y, hit_point_z;
	logic [63:0] hit_sqr_distance;
	logic [15:0] hit_index;
	int fail_count, pending_results, result_count, hit_count;

	logic in_taken;
	int send_idle_pct, recv_stall_pct;
	int cycles, tri_count;
	longint ray_o[3], ray_d[3];

	nearest_ray_triangle_hit_core DUT (.*);
	nrth_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic set_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
			longint dz, logic seg, logic [31:0] thr);
		ray_o = '{ox, oy, oz};
		ray_d = '{dx, dy, dz};
		write_reg(REG_ORIGIN_X, ox[31:0]);
		write_reg(REG_ORIGIN_Y, oy[31:0]);
		write_reg(REG_ORIGIN_Z, oz[31:0]);
		write_reg(REG_DIR_X, dx[31:0]);
		write_reg(REG_DIR_Y, dy[31:0]);
		write_reg(REG_DIR_Z, dz[31:0]);
		write_reg(REG_SEGMENT_MODE, {31'd0, seg});
		write_reg(REG_NEAR_THRESHOLD, thr);
	endtask

	task automatic send_triangle(logic [8:0][31:0] v, logic [15:0] idx, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		{vertex_c_z, vertex_c_y, vertex_c_x, vertex_b_z, vertex_b_y, vertex_b_x,
			vertex_a_z, vertex_a_y, vertex_a_x} = v;
		tri_index = idx;
		last = fin;
		in_valid = 1;
		do @(negedge clk); while (!in_taken);
		in_valid = 0;
		tri_count++;
	endtask

	function automatic logic [8:0][31:0] pack_tri(longint a[3], longint b[3], longint c[3]);
		return {c[2][31:0], c[1][31:0], c[0][31:0], b[2][31:0], b[1][31:0], b[0][31:0],
			a[2][31:0], a[1][31:0], a[0][31:0]};
	endfunction

	// triangle around a point on the ray at parameter k (Q16.16), centroid on the ray
	function automatic logic [8:0][31:0] tri_on_ray(longint k);
		longint p[3], u1[3], u2[3], a[3], b[3], c[3];
		int sh;
		sh = $urandom_range(20, 8);
		for (int i = 0; i < 3; i++) begin
			p[i] = ray_o[i] + ((ray_d[i] * k) >>> 16);
			u1[i] = longint'($signed($urandom)) >>> (32 - sh);
			u2[i] = longint'($signed($urandom)) >>> (32 - sh);
			a[i] = p[i] - u1[i] - u2[i];
			b[i] = a[i] + 3 * u1[i];
			c[i] = a[i] + 3 * u2[i];
		end
		return pack_tri(a, b, c);
	endfunction

	function automatic logic [8:0][31:0] random_triangle();
		logic [8:0][31:0] v;
		int kind;
		kind = $urandom_range(99);
		if (kind < 70) return tri_on_ray(longint'($urandom_range(2 << 16)));
		if (kind < 80) return tri_on_ray(-longint'($urandom_range(1 << 17, 1)));
		if (kind < 90) begin
			v = tri_on_ray(longint'($urandom_range(1 << 16)));
			v[5:3] = v[2:0];
			return v;
		end
		for (int i = 0; i < 9; i++) v[i] = $urandom;
		return v;
	endfunction

	task automatic drain();
		while (pending_results != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic directed_runs();
		logic [8:0][31:0] v;
		// flat triangle across the z axis at z=5 and z=2
		v = {32'sd0, 32'sd1 <<< 17, -32'sd1 <<< 16, 32'sd5 <<< 16, -32'sd1 <<< 16,
			32'sd1 <<< 17, 32'sd5 <<< 16, -32'sd1 <<< 16, -32'sd1 <<< 16};
		v[2] = 32'sd5 <<< 16;
		v[8] = 32'sd5 <<< 16;
		send_triangle(v, 16'h0000, 1);
		send_triangle(v, 16'hFFFF, 0);
		v[2] = 32'sd2 <<< 16; v[5] = 32'sd2 <<< 16; v[8] = 32'sd2 <<< 16;
		send_triangle(v, 16'h1234, 1);
		// behind the origin
		v[2] = -32'sd3 <<< 16; v[5] = -32'sd3 <<< 16; v[8] = -32'sd3 <<< 16;
		send_triangle(v, 16'h0001, 1);
		// very near hit stops the run, the later nearer one is ignored
		v[2] = 32'sd4; v[5] = 32'sd4; v[8] = 32'sd4;
		send_triangle(v, 16'h00AA, 0);
		v[2] = 32'sd1; v[5] = 32'sd1; v[8] = 32'sd1;
		send_triangle(v, 16'h00BB, 1);
		// plane containing the ray direction
		v = {32'sd1 <<< 16, 32'sd0, 32'sd1 <<< 16, 32'sd0, 32'sd1 <<< 16, 32'sd1 <<< 16,
			32'sd0, 32'sd0, 32'sd1 <<< 16};
		send_triangle(v, 16'h0002, 1);
		// degenerate: all vertices equal
		send_triangle({9{32'sd3 <<< 16}}, 16'h0003, 1);
		send_triangle({9{32'h7FFFFFFF}}, 16'hFFFF, 0);
		send_triangle({9{32'h80000000}}, 16'h8000, 0);
		send_triangle({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
			16'h7FFF, 1);
		send_triangle({32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000},
			16'h5555, 1);
	endtask

	initial begin
		logic fin;
		arst_n = 0;
		cycles = 0;
		tri_count = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		{vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z} = '0;
		{vertex_c_x, vertex_c_y, vertex_c_z} = '0;
		tri_index = '0;
		last = 0;
		out_stall = 0;
		send_idle_pct = 33;
		recv_stall_pct = 81;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = ph < 2 ? 33 : (ph < 4 ? 81 : 0);
			recv_stall_pct = ph < 2 ? 81 : (ph < 4 ? 33 : 0);
			case (ph)
				0: set_ray(0, 0, 0, 0, 0, 1 << 16, 0, THRESH_RESET);
				1: set_ray(1 << 16, 2 << 16, 3 << 16, 1 << 16, 1 << 15, -(1 << 14), 1, 0);
				2: set_ray(-64'sd2147483648, 64'sd2147483647, 0, 64'sd2147483647,
					-64'sd2147483648, 1 << 16, 0, 32'hFFFFFFFF);
				3: set_ray(-(5 << 16), 7 << 16, 1 << 16, 3 << 12, -(2 << 16), 5 << 16, 1, 8);
				default: set_ray(longint'($signed($urandom)) >>> 10,
					longint'($signed($urandom)) >>> 10, longint'($signed($urandom)) >>> 10,
					longint'($signed($urandom)) >>> 12, longint'($signed($urandom)) >>> 12,
					longint'($signed($urandom)) >>> 12, $urandom_range(1),
					$urandom_range(4000));
			endcase
			if (ph == 0) directed_runs();
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				fin = (i == ITEMS_PER_PHASE - 1) || ($urandom_range(3) == 0);
				send_triangle(random_triangle(), 16'($urandom), fin);
			end
			drain();
		end
		$display("%0d triangles in 6 ray setups, %0d run results (%0d with a hit)",
			tri_count, result_count, hit_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
